[rtl/bcdsw_pkg.sv]
package bcdsw_pkg;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_PAUSE  = 3'd2;
    localparam logic [2:0] OP_RESUME = 3'd3;
    localparam logic [2:0] OP_TOGGLE = 3'd4;
    localparam logic [2:0] OP_ADJUST = 3'd5;

    localparam logic [1:0] FIELD_HOURS   = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;
    localparam logic [1:0] FIELD_SECONDS = 2'd2;

    // Two-digit BCD values, tens digit in the upper nibble.
    localparam logic [7:0] BCD_ZERO     = 8'h00;
    localparam logic [7:0] BCD_MAX_MS   = 8'h59;
    localparam logic [7:0] BCD_MAX_HADJ = 8'h23;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic [3:0] hours_tens;
        logic [3:0] hours_ones;
        logic [2:0] minutes_tens;
        logic [3:0] minutes_ones;
        logic [2:0] seconds_tens;
        logic [3:0] seconds_ones;
        logic       down_mode;
        logic       is_paused;
        logic       buzzer_on;
    } t_state;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] adjust_field;
        logic       adjust_up;
    } t_event;

    // Increment of a valid BCD pair; 99 rolls over to 00.
    function automatic logic [7:0] bcd_inc(input logic [7:0] v);
        logic [7:0] r;
        if (v[3:0] == 4'd9) begin
            r = (v[7:4] == 4'd9) ? BCD_ZERO : {v[7:4] + 4'd1, 4'd0};
        end else begin
            r = {v[7:4], v[3:0] + 4'd1};
        end
        return r;
    endfunction

    // Decrement of a valid, non-zero BCD pair.
    function automatic logic [7:0] bcd_dec(input logic [7:0] v);
        logic [7:0] r;
        if (v[3:0] == 4'd0) begin
            r = {v[7:4] - 4'd1, 4'd9};
        end else begin
            r = {v[7:4], v[3:0] - 4'd1};
        end
        return r;
    endfunction

endpackage

[rtl/bcd_up_down_stopwatch_top.sv]
// HH:MM:SS up/down timer with six BCD digits, a mode bit, a pause bit and a buzzer.
// Each request on the slave stream is one event: tuser carries the opcode (tick,
// clear digits, pause, resume, toggle mode, adjust) and tdata the adjust field
// select and direction. Each event gives exactly one result on the master stream
// holding all digits and the three status bits.
// The update is combinational: an accepted event is written into the state
// register at that clock edge and the result is offered on the next cycle, and
// one event can be taken every cycle while the receiver does not stall.
// The state register doubles as the result register; its valid flag is the only
// buffering, and a new event is taken in the same cycle as the pending result is
// drained. If the receiver stalls, s_axis_tready falls and the result holds.
// Synchronous reset clears the digits to 00:00:00, selects count-up, clears the
// pause and buzzer bits and empties the result register.
module bcd_up_down_stopwatch_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [1:0] adjust_field, [2] adjust_up, rest zero
    input  logic [bcdsw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [2:0] opcode
    input  logic [bcdsw_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [3:0] hours_tens, [7:4] hours_ones, [10:8] minutes_tens, [14:11] minutes_ones,
    // [17:15] seconds_tens, [21:18] seconds_ones, [22] down_mode, [23] is_paused,
    // [24] buzzer_on, rest zero
    output logic [bcdsw_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import bcdsw_pkg::*;

    t_state r_state;
    t_state n_state;
    t_event in_event;
    logic   r_out_valid;
    logic   accept;

    assign in_event.opcode       = s_axis_tuser;
    assign in_event.adjust_field = s_axis_tdata[1:0];
    assign in_event.adjust_up    = s_axis_tdata[2];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bcdsw_next u_next (
        .i_state (r_state),
        .i_event (in_event),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            r_state.buzzer_on,
                            r_state.is_paused,
                            r_state.down_mode,
                            r_state.seconds_ones,
                            r_state.seconds_tens,
                            r_state.minutes_ones,
                            r_state.minutes_tens,
                            r_state.hours_ones,
                            r_state.hours_tens};

`ifndef NO_ASSERTIONS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted event produced no result");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("event taken while result stalled");

    a_state_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_state))
        else $error("state changed without an event");

    a_paused_down_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.down_mode && r_state.is_paused) |-> !r_state.buzzer_on)
        else $error("buzzer on while count-down is paused");

    a_digits_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.hours_tens <= 4'd9) && (r_state.hours_ones <= 4'd9) &&
        (r_state.minutes_tens <= 3'd5) && (r_state.minutes_ones <= 4'd9) &&
        (r_state.seconds_tens <= 3'd5) && (r_state.seconds_ones <= 4'd9))
        else $error("time digits out of range");
`endif

endmodule

[rtl/bcdsw_next.sv]
module bcdsw_next (
    input  bcdsw_pkg::t_state i_state,
    input  bcdsw_pkg::t_event i_event,
    output bcdsw_pkg::t_state o_state
);
    import bcdsw_pkg::*;

    logic [7:0] hh;
    logic [7:0] mm;
    logic [7:0] ss;
    logic [7:0] n_hh;
    logic [7:0] n_mm;
    logic [7:0] n_ss;
    logic       n_mode;
    logic       n_paused;
    logic       n_alarm;
    logic       allow_adj;

    assign hh = {i_state.hours_tens, i_state.hours_ones};
    assign mm = {1'b0, i_state.minutes_tens, i_state.minutes_ones};
    assign ss = {1'b0, i_state.seconds_tens, i_state.seconds_ones};
    assign allow_adj = i_state.down_mode && i_state.is_paused;

    always_comb begin
        n_hh     = hh;
        n_mm     = mm;
        n_ss     = ss;
        n_mode   = i_state.down_mode;
        n_paused = i_state.is_paused;
        n_alarm  = i_state.buzzer_on;

        unique case (i_event.opcode)
            OP_TICK: begin
                if (!i_state.down_mode) begin
                    n_alarm = 1'b0;
                    if (!i_state.is_paused) begin
                        if (ss == BCD_MAX_MS) begin
                            n_ss = BCD_ZERO;
                            if (mm == BCD_MAX_MS) begin
                                n_mm = BCD_ZERO;
                                n_hh = bcd_inc(hh);
                            end else begin
                                n_mm = bcd_inc(mm);
                            end
                        end else begin
                            n_ss = bcd_inc(ss);
                        end
                    end
                end else if (!i_state.is_paused) begin
                    // At zero the count holds and the buzzer goes on.
                    if (hh == BCD_ZERO && mm == BCD_ZERO && ss == BCD_ZERO) begin
                        n_alarm = 1'b1;
                    end else if (ss != BCD_ZERO) begin
                        n_ss = bcd_dec(ss);
                    end else begin
                        n_ss = BCD_MAX_MS;
                        if (mm != BCD_ZERO) begin
                            n_mm = bcd_dec(mm);
                        end else begin
                            n_mm = BCD_MAX_MS;
                            n_hh = bcd_dec(hh);
                        end
                    end
                end
            end
            OP_CLEAR: begin
                n_hh = BCD_ZERO;
                n_mm = BCD_ZERO;
                n_ss = BCD_ZERO;
            end
            OP_PAUSE:  n_paused = 1'b1;
            OP_RESUME: n_paused = 1'b0;
            OP_TOGGLE: n_mode = !i_state.down_mode;
            OP_ADJUST: begin
                if (allow_adj) begin
                    unique case (i_event.adjust_field)
                        FIELD_HOURS: begin
                            if (i_event.adjust_up) begin
                                if (hh < BCD_MAX_HADJ) n_hh = bcd_inc(hh);
                            end else if (hh != BCD_ZERO) begin
                                n_hh = bcd_dec(hh);
                            end
                        end
                        FIELD_MINUTES: begin
                            if (i_event.adjust_up) begin
                                if (mm < BCD_MAX_MS) n_mm = bcd_inc(mm);
                            end else if (mm != BCD_ZERO) begin
                                n_mm = bcd_dec(mm);
                            end
                        end
                        FIELD_SECONDS: begin
                            if (i_event.adjust_up) begin
                                if (ss < BCD_MAX_MS) n_ss = bcd_inc(ss);
                            end else if (ss != BCD_ZERO) begin
                                n_ss = bcd_dec(ss);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        // The buzzer is always silenced while count-down mode is paused.
        if (n_mode && n_paused) n_alarm = 1'b0;

        o_state.hours_tens   = n_hh[7:4];
        o_state.hours_ones   = n_hh[3:0];
        o_state.minutes_tens = n_mm[6:4];
        o_state.minutes_ones = n_mm[3:0];
        o_state.seconds_tens = n_ss[6:4];
        o_state.seconds_ones = n_ss[3:0];
        o_state.down_mode    = n_mode;
        o_state.is_paused    = n_paused;
        o_state.buzzer_on    = n_alarm;
    end

endmodule
